[rtl/bsu_pkg.sv]
// ============================================================================
// bsu_pkg - boid steering update shared types and constants
// Transaction payloads, sequencer states, opcodes, register indexes and the
// fixed widths of the steering datapath.
// ============================================================================
`timescale 1ns / 1ps

package bsu_pkg;

   localparam int DATA_W      = 32;
   localparam int UNIT_W      = 14;   // unit vector component, [-4096,4096]
   localparam int ACC_W       = 44;   // summed weighted forces
   localparam int MAG_W       = 31;   // root of a scaled sum of squares
   localparam int SQ_W        = 62;   // scaled sum of squares
   localparam int ROOT_W      = 64;
   localparam int DIV_N_W     = 62;   // dividend width of the shared divider
   localparam int PROD_W      = 64;
   localparam int TMP_W       = 44;

   localparam logic [5:0] DIV_LAST   = 6'd61;
   localparam logic [5:0] SQRT_FIRST = 6'd31;

   localparam logic [31:0] UNIT_ONE  = 32'd4096;
   localparam logic [63:0] NORM_HI   = 64'd1 << 30;
   localparam logic [63:0] NORM_LO   = 64'd1 << 29;

   localparam logic [2:0] OP_OWN      = 3'd0;
   localparam logic [2:0] OP_AIM      = 3'd1;
   localparam logic [2:0] OP_NEIGHBOR = 3'd2;
   localparam logic [2:0] OP_PROBE    = 3'd3;
   localparam logic [2:0] OP_FINISH   = 3'd4;

   localparam logic [2:0] CSR_TARGET_WEIGHT     = 3'd0;
   localparam logic [2:0] CSR_AVOID_WEIGHT      = 3'd1;
   localparam logic [2:0] CSR_SEPARATION_WEIGHT = 3'd2;
   localparam logic [2:0] CSR_COHESION_WEIGHT   = 3'd3;
   localparam logic [2:0] CSR_ALIGNMENT_WEIGHT  = 3'd4;
   localparam logic [2:0] CSR_MIN_SPEED         = 3'd5;
   localparam logic [2:0] CSR_MAX_SPEED         = 3'd6;
   localparam logic [2:0] CSR_DELTA_TIME        = 3'd7;

   typedef struct packed {
      logic [2:0]         op;
      logic signed [31:0] vec_a_x;
      logic signed [31:0] vec_a_y;
      logic signed [31:0] vec_a_z;
      logic signed [31:0] vec_b_x;
      logic signed [31:0] vec_b_y;
      logic signed [31:0] vec_b_z;
      logic               flag;
   } req_type;

   typedef struct packed {
      logic signed [31:0] dest_x;
      logic signed [31:0] dest_y;
      logic signed [31:0] dest_z;
   } rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DIR,
      ST_DMUL,
      ST_DSUB,
      ST_NABS,
      ST_NSHIFT,
      ST_NSQ_MUL,
      ST_NSQ_ACC,
      ST_NSQRT,
      ST_NSPD,
      ST_NCLAMP,
      ST_NDIV_MUL,
      ST_NDIV_LD,
      ST_NDIV,
      ST_NRET,
      ST_FMUL1,
      ST_FSUB,
      ST_FMUL2,
      ST_FACC,
      ST_VMUL_HI,
      ST_VMUL_LO,
      ST_VADD,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      MODE_PROBE,
      MODE_FORCE,
      MODE_FINAL
   } mode_type;

   typedef enum logic [2:0] {
      FRC_TARGET,
      FRC_AVOID,
      FRC_SEPAR,
      FRC_COHES,
      FRC_ALIGN
   } force_type;

endpackage

[rtl/boid_steering_update.sv]
// ============================================================================
// boid_steering_update - fixed point boid steering
// Gathers one boid's state, neighbors and probes, then on a finish
// transaction forms five normalized steering forces, integrates velocity,
// clamps speed and returns the next destination. One shared multiplier,
// square root and divider run under a single sequencer.
// ============================================================================
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  bsu_pkg::req_type
//   rsp      out        rsp_valid / rsp_stall  bsu_pkg::rsp_type
//   csr      in         csr_write_en           csr_index, csr_wdata
//
// Load, neighbor and ignored transactions are taken without leaving the idle state.
// A clear probe and a finish are paced by the 62-step divider, the 32-step
// root and the one-bit-per-cycle scaling shift, all per normalization.
// req_stall is high while a probe or finish is in work, and a finish waits
// in its last state while the previous result is still stalled.
// Reset is synchronous and needs no clearing pass.
`timescale 1ns / 1ps

module boid_steering_update #(
   parameter int MAX_NEIGHBORS = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  bsu_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output bsu_pkg::rsp_type rsp_data,
   input  logic             csr_write_en,
   input  logic [2:0]       csr_index,
   input  logic [30:0]      csr_wdata
);

   localparam int CNT_W = $clog2(MAX_NEIGHBORS + 1);
   localparam int SUM_W = 32 + CNT_W;
   localparam int VEC_W = (SUM_W + 1 > 45) ? SUM_W + 1 : 45;
   localparam int SH_W  = $clog2(VEC_W + 1);

   // control
   bsu_pkg::state_type state_ff, state_in;
   bsu_pkg::mode_type  mode_ff, mode_in;
   bsu_pkg::force_type frc_ff, frc_in;
   logic [1:0]         idx_ff, idx_in;
   logic [5:0]         cnt_ff, cnt_in;
   logic [SH_W-1:0]    lsh_ff, lsh_in, rsh_ff, rsh_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // configuration
   logic [15:0] w_target_ff, w_target_in, w_avoid_ff, w_avoid_in;
   logic [15:0] w_separ_ff, w_separ_in, w_cohes_ff, w_cohes_in;
   logic [15:0] w_align_ff, w_align_in, dt_ff, dt_in;
   logic [30:0] min_speed_ff, min_speed_in, max_speed_ff, max_speed_in;

   // boid state
   logic signed [31:0]        pos_ff [3], pos_in [3];
   logic signed [31:0]        vel_ff [3], vel_in [3];
   logic signed [31:0]        head_ff [3], head_in [3];
   logic signed [31:0]        tgt_ff [3], tgt_in [3];
   logic signed [SUM_W-1:0]   psum_ff [3], psum_in [3];
   logic signed [SUM_W-1:0]   vsum_ff [3], vsum_in [3];
   logic signed [bsu_pkg::UNIT_W-1:0] avoid_ff [3], avoid_in [3];
   logic [CNT_W-1:0]          ncnt_ff, ncnt_in;
   logic                      tvalid_ff, tvalid_in, found_ff, found_in;

   // datapath
   logic signed [VEC_W-1:0]          vec_ff [3], vec_in [3];
   logic [VEC_W-1:0]                 m_ff [3], m_in [3];
   logic                             neg_ff [3], neg_in [3];
   logic [31:0]                      q_ff [3], q_in [3];
   logic signed [bsu_pkg::ACC_W-1:0] acc_ff [3], acc_in [3];
   logic [bsu_pkg::SQ_W-1:0]         sq_ff, sq_in;
   logic [bsu_pkg::ROOT_W-1:0]       root_ff, root_in;
   logic [bsu_pkg::MAG_W-1:0]        rem_ff, rem_in;
   logic [bsu_pkg::DIV_N_W-1:0]      dnum_ff, dnum_in;
   logic [31:0]                      speed_ff, speed_in;
   logic [bsu_pkg::PROD_W-1:0]       prod_ff, prod_in;
   logic [bsu_pkg::TMP_W-1:0]        tmp_ff, tmp_in;
   logic [31:0]                      fmag_ff, fmag_in;
   logic                             fneg_ff, fneg_in;
   bsu_pkg::rsp_type                 rsp_data_ff, rsp_data_in;

   // helpers
   logic signed [31:0]        req_a [3], req_b [3];
   logic                      accept;
   logic [VEC_W-1:0]          mx;
   logic [bsu_pkg::MAG_W-1:0] mag;
   logic [31:0]               mul_a, mul_b;
   logic [15:0]               weight;
   logic [31:0]               pos_abs;
   logic [bsu_pkg::ACC_W-1:0] acc_abs;
   logic [bsu_pkg::ROOT_W-1:0] sq_bit, sq_try;
   logic                      sq_ge;
   logic [31:0]               rem_sh;
   logic                      d_ge;
   logic signed [32:0]        f_scaled;
   logic signed [33:0]        f_val;
   logic signed [bsu_pkg::ACC_W-1:0] f_add;
   logic [bsu_pkg::TMP_W-1:0] v_mag;
   logic signed [VEC_W-1:0]   v_delta;
   logic signed [VEC_W-1:0]   d_prod, d_diff;
   logic signed [31:0]        dest [3];

   assign req_a[0] = req_data.vec_a_x;
   assign req_a[1] = req_data.vec_a_y;
   assign req_a[2] = req_data.vec_a_z;
   assign req_b[0] = req_data.vec_b_x;
   assign req_b[1] = req_data.vec_b_y;
   assign req_b[2] = req_data.vec_b_z;

   assign req_stall = (state_ff != bsu_pkg::ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign mag       = root_ff[bsu_pkg::MAG_W-1:0];

   always_comb begin
      mx = m_ff[0];
      if (m_ff[1] > mx) begin
         mx = m_ff[1];
      end
      if (m_ff[2] > mx) begin
         mx = m_ff[2];
      end
   end

   always_comb begin
      unique case (frc_ff)
         bsu_pkg::FRC_TARGET: weight = w_target_ff;
         bsu_pkg::FRC_AVOID:  weight = w_avoid_ff;
         bsu_pkg::FRC_SEPAR:  weight = w_separ_ff;
         bsu_pkg::FRC_COHES:  weight = w_cohes_ff;
         bsu_pkg::FRC_ALIGN:  weight = w_align_ff;
         default:             weight = w_align_ff;
      endcase
   end

   assign pos_abs = pos_ff[idx_ff][31] ? 32'(-pos_ff[idx_ff]) : 32'(pos_ff[idx_ff]);
   assign acc_abs = acc_ff[idx_ff][bsu_pkg::ACC_W-1] ? bsu_pkg::ACC_W'(-acc_ff[idx_ff])
                                                     : bsu_pkg::ACC_W'(acc_ff[idx_ff]);

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         bsu_pkg::ST_DMUL: begin
            mul_a = pos_abs;
            mul_b = 32'(ncnt_ff);
         end
         bsu_pkg::ST_NSQ_MUL: begin
            mul_a = m_ff[idx_ff][31:0];
            mul_b = m_ff[idx_ff][31:0];
         end
         bsu_pkg::ST_NDIV_MUL: begin
            mul_a = m_ff[idx_ff][31:0];
            mul_b = (mode_ff == bsu_pkg::MODE_FINAL) ? speed_ff : bsu_pkg::UNIT_ONE;
         end
         bsu_pkg::ST_FMUL1: begin
            mul_a = q_ff[idx_ff];
            mul_b = {1'b0, max_speed_ff};
         end
         bsu_pkg::ST_FMUL2: begin
            mul_a = fmag_ff;
            mul_b = 32'(weight);
         end
         bsu_pkg::ST_VMUL_HI: begin
            mul_a = 32'(acc_abs[bsu_pkg::ACC_W-1:16]);
            mul_b = 32'(dt_ff);
         end
         bsu_pkg::ST_VMUL_LO: begin
            mul_a = 32'(acc_abs[15:0]);
            mul_b = 32'(dt_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // square root step
   assign sq_bit = bsu_pkg::ROOT_W'(1) << {cnt_ff[4:0], 1'b0};
   assign sq_try = root_ff + sq_bit;
   assign sq_ge  = {2'b00, sq_ff} >= sq_try;

   // restoring divide step
   assign rem_sh = {rem_ff, dnum_ff[bsu_pkg::DIV_N_W-1]};
   assign d_ge   = rem_sh >= {1'b0, mag};

   // force terms
   assign f_scaled = neg_ff[idx_ff] ? -$signed({1'b0, prod_ff[43:12]})
                                    : $signed({1'b0, prod_ff[43:12]});
   assign f_val    = 34'(f_scaled) - 34'(vel_ff[idx_ff]);
   assign f_add    = fneg_ff ? -$signed({4'b0000, prod_ff[47:8]})
                             : $signed({4'b0000, prod_ff[47:8]});

   // velocity update
   assign v_mag   = tmp_ff + bsu_pkg::TMP_W'(prod_ff[31:16]);
   assign v_delta = acc_ff[idx_ff][bsu_pkg::ACC_W-1] ? -$signed(VEC_W'(v_mag))
                                                     : $signed(VEC_W'(v_mag));

   // neighbor centre offset
   assign d_prod = pos_ff[idx_ff][31] ? -$signed(prod_ff[VEC_W-1:0])
                                      : $signed(prod_ff[VEC_W-1:0]);
   assign d_diff = d_prod - VEC_W'(psum_ff[idx_ff]);

   always_comb begin
      logic signed [32:0] c;
      logic signed [33:0] r;
      for (int i = 0; i < 3; i++) begin
         c = neg_ff[i] ? -$signed({1'b0, q_ff[i]}) : $signed({1'b0, q_ff[i]});
         r = 34'(pos_ff[i]) + 34'(c);
         if (r > 34'sd2147483647) begin
            dest[i] = 32'sh7FFFFFFF;
         end else if (r < -34'sd2147483648) begin
            dest[i] = 32'sh80000000;
         end else begin
            dest[i] = r[31:0];
         end
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      frc_in       = frc_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      lsh_in       = lsh_ff;
      rsh_in       = rsh_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      w_target_in  = w_target_ff;
      w_avoid_in   = w_avoid_ff;
      w_separ_in   = w_separ_ff;
      w_cohes_in   = w_cohes_ff;
      w_align_in   = w_align_ff;
      dt_in        = dt_ff;
      min_speed_in = min_speed_ff;
      max_speed_in = max_speed_ff;
      ncnt_in      = ncnt_ff;
      tvalid_in    = tvalid_ff;
      found_in     = found_ff;
      sq_in        = sq_ff;
      root_in      = root_ff;
      rem_in       = rem_ff;
      dnum_in      = dnum_ff;
      speed_in     = speed_ff;
      prod_in      = 64'(mul_a) * 64'(mul_b);
      tmp_in       = tmp_ff;
      fmag_in      = fmag_ff;
      fneg_in      = fneg_ff;
      for (int i = 0; i < 3; i++) begin
         pos_in[i]   = pos_ff[i];
         vel_in[i]   = vel_ff[i];
         head_in[i]  = head_ff[i];
         tgt_in[i]   = tgt_ff[i];
         psum_in[i]  = psum_ff[i];
         vsum_in[i]  = vsum_ff[i];
         avoid_in[i] = avoid_ff[i];
         vec_in[i]   = vec_ff[i];
         m_in[i]     = m_ff[i];
         neg_in[i]   = neg_ff[i];
         q_in[i]     = q_ff[i];
         acc_in[i]   = acc_ff[i];
      end

      if (csr_write_en) begin
         unique case (csr_index)
            bsu_pkg::CSR_TARGET_WEIGHT:     w_target_in  = csr_wdata[15:0];
            bsu_pkg::CSR_AVOID_WEIGHT:      w_avoid_in   = csr_wdata[15:0];
            bsu_pkg::CSR_SEPARATION_WEIGHT: w_separ_in   = csr_wdata[15:0];
            bsu_pkg::CSR_COHESION_WEIGHT:   w_cohes_in   = csr_wdata[15:0];
            bsu_pkg::CSR_ALIGNMENT_WEIGHT:  w_align_in   = csr_wdata[15:0];
            bsu_pkg::CSR_MIN_SPEED:         min_speed_in = csr_wdata;
            bsu_pkg::CSR_MAX_SPEED:         max_speed_in = csr_wdata;
            bsu_pkg::CSR_DELTA_TIME:        dt_in        = csr_wdata[15:0];
         endcase
      end

      unique case (state_ff)
         bsu_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (req_data.op)
                  bsu_pkg::OP_OWN: begin
                     for (int i = 0; i < 3; i++) begin
                        pos_in[i] = req_a[i];
                        vel_in[i] = req_b[i];
                     end
                  end
                  bsu_pkg::OP_AIM: begin
                     for (int i = 0; i < 3; i++) begin
                        head_in[i] = req_a[i];
                        tgt_in[i]  = req_b[i];
                     end
                     tvalid_in = req_data.flag;
                  end
                  bsu_pkg::OP_NEIGHBOR: begin
                     if (ncnt_ff < CNT_W'(MAX_NEIGHBORS)) begin
                        for (int i = 0; i < 3; i++) begin
                           psum_in[i] = psum_ff[i] + SUM_W'(req_a[i]);
                           vsum_in[i] = vsum_ff[i] + SUM_W'(req_b[i]);
                        end
                        ncnt_in = ncnt_ff + 1'b1;
                     end
                  end
                  bsu_pkg::OP_PROBE: begin
                     if (req_data.flag && !found_ff) begin
                        for (int i = 0; i < 3; i++) begin
                           vec_in[i] = VEC_W'(req_a[i]) - VEC_W'(pos_ff[i]);
                        end
                        mode_in  = bsu_pkg::MODE_PROBE;
                        state_in = bsu_pkg::ST_NABS;
                     end
                  end
                  bsu_pkg::OP_FINISH: begin
                     for (int i = 0; i < 3; i++) begin
                        acc_in[i] = '0;
                     end
                     frc_in   = bsu_pkg::FRC_TARGET;
                     mode_in  = bsu_pkg::MODE_FORCE;
                     state_in = bsu_pkg::ST_DIR;
                  end
                  default: begin
                  end
               endcase
            end
         end

         bsu_pkg::ST_DIR: begin
            state_in = bsu_pkg::ST_NABS;
            unique case (frc_ff)
               bsu_pkg::FRC_TARGET: begin
                  for (int i = 0; i < 3; i++) begin
                     vec_in[i] = tvalid_ff ? VEC_W'(tgt_ff[i]) - VEC_W'(pos_ff[i]) : '0;
                  end
               end
               bsu_pkg::FRC_AVOID: begin
                  for (int i = 0; i < 3; i++) begin
                     vec_in[i] = found_ff ? VEC_W'(avoid_ff[i]) : VEC_W'(head_ff[i]);
                  end
               end
               bsu_pkg::FRC_SEPAR, bsu_pkg::FRC_COHES: begin
                  idx_in   = 2'd0;
                  state_in = bsu_pkg::ST_DMUL;
               end
               bsu_pkg::FRC_ALIGN: begin
                  for (int i = 0; i < 3; i++) begin
                     vec_in[i] = VEC_W'(vsum_ff[i]);
                  end
               end
               default: begin
                  state_in = bsu_pkg::ST_IDLE;
               end
            endcase
         end

         bsu_pkg::ST_DMUL: begin
            state_in = bsu_pkg::ST_DSUB;
         end

         bsu_pkg::ST_DSUB: begin
            vec_in[idx_ff] = (frc_ff == bsu_pkg::FRC_COHES) ? -d_diff : d_diff;
            if (idx_ff == 2'd2) begin
               state_in = bsu_pkg::ST_NABS;
            end else begin
               idx_in   = idx_ff + 2'd1;
               state_in = bsu_pkg::ST_DMUL;
            end
         end

         bsu_pkg::ST_NABS: begin
            for (int i = 0; i < 3; i++) begin
               neg_in[i] = vec_ff[i][VEC_W-1];
               m_in[i]   = vec_ff[i][VEC_W-1] ? VEC_W'(-vec_ff[i]) : VEC_W'(vec_ff[i]);
               q_in[i]   = '0;
            end
            lsh_in = '0;
            rsh_in = '0;
            sq_in  = '0;
            if (vec_ff[0] == '0 && vec_ff[1] == '0 && vec_ff[2] == '0) begin
               state_in = bsu_pkg::ST_NRET;
            end else begin
               state_in = bsu_pkg::ST_NSHIFT;
            end
         end

         bsu_pkg::ST_NSHIFT: begin
            priority if (64'(mx) >= bsu_pkg::NORM_HI) begin
               for (int i = 0; i < 3; i++) begin
                  m_in[i] = m_ff[i] >> 1;
               end
               rsh_in = rsh_ff + 1'b1;
            end else if (64'(mx) < bsu_pkg::NORM_LO) begin
               for (int i = 0; i < 3; i++) begin
                  m_in[i] = m_ff[i] << 1;
               end
               lsh_in = lsh_ff + 1'b1;
            end else begin
               idx_in   = 2'd0;
               state_in = bsu_pkg::ST_NSQ_MUL;
            end
         end

         bsu_pkg::ST_NSQ_MUL: begin
            state_in = bsu_pkg::ST_NSQ_ACC;
         end

         bsu_pkg::ST_NSQ_ACC: begin
            sq_in = sq_ff + prod_ff[bsu_pkg::SQ_W-1:0];
            if (idx_ff == 2'd2) begin
               root_in  = '0;
               cnt_in   = bsu_pkg::SQRT_FIRST;
               state_in = bsu_pkg::ST_NSQRT;
            end else begin
               idx_in   = idx_ff + 2'd1;
               state_in = bsu_pkg::ST_NSQ_MUL;
            end
         end

         bsu_pkg::ST_NSQRT: begin
            if (sq_ge) begin
               sq_in   = sq_ff - sq_try[bsu_pkg::SQ_W-1:0];
               root_in = (root_ff >> 1) + sq_bit;
            end else begin
               root_in = root_ff >> 1;
            end
            if (cnt_ff == '0) begin
               idx_in = 2'd0;
               if (mode_ff == bsu_pkg::MODE_FINAL) begin
                  speed_in = 32'(root_in);
                  state_in = bsu_pkg::ST_NSPD;
               end else begin
                  state_in = bsu_pkg::ST_NDIV_MUL;
               end
            end else begin
               cnt_in = cnt_ff - 6'd1;
            end
         end

         bsu_pkg::ST_NSPD: begin
            priority if (rsh_ff != '0) begin
               speed_in = speed_ff[31] ? '1 : (speed_ff << 1);
               rsh_in   = rsh_ff - 1'b1;
            end else if (lsh_ff != '0) begin
               speed_in = speed_ff >> 1;
               lsh_in   = lsh_ff - 1'b1;
            end else begin
               state_in = bsu_pkg::ST_NCLAMP;
            end
         end

         bsu_pkg::ST_NCLAMP: begin
            priority if (speed_ff < {1'b0, min_speed_ff}) begin
               speed_in = {1'b0, min_speed_ff};
            end else if (speed_ff >= {1'b0, max_speed_ff}) begin
               speed_in = {1'b0, max_speed_ff};
            end
            state_in = bsu_pkg::ST_NDIV_MUL;
         end

         bsu_pkg::ST_NDIV_MUL: begin
            state_in = bsu_pkg::ST_NDIV_LD;
         end

         bsu_pkg::ST_NDIV_LD: begin
            dnum_in  = prod_ff[bsu_pkg::DIV_N_W-1:0];
            rem_in   = '0;
            cnt_in   = '0;
            state_in = bsu_pkg::ST_NDIV;
         end

         bsu_pkg::ST_NDIV: begin
            rem_in  = d_ge ? bsu_pkg::MAG_W'(rem_sh - {1'b0, mag})
                           : rem_sh[bsu_pkg::MAG_W-1:0];
            dnum_in = {dnum_ff[bsu_pkg::DIV_N_W-2:0], d_ge};
            if (cnt_ff == bsu_pkg::DIV_LAST) begin
               q_in[idx_ff] = {dnum_ff[30:0], d_ge};
               if (idx_ff == 2'd2) begin
                  state_in = bsu_pkg::ST_NRET;
               end else begin
                  idx_in   = idx_ff + 2'd1;
                  state_in = bsu_pkg::ST_NDIV_MUL;
               end
            end else begin
               cnt_in = cnt_ff + 6'd1;
            end
         end

         bsu_pkg::ST_NRET: begin
            unique case (mode_ff)
               bsu_pkg::MODE_PROBE: begin
                  for (int i = 0; i < 3; i++) begin
                     avoid_in[i] = neg_ff[i] ? -$signed(bsu_pkg::UNIT_W'(q_ff[i]))
                                             : $signed(bsu_pkg::UNIT_W'(q_ff[i]));
                  end
                  found_in = 1'b1;
                  state_in = bsu_pkg::ST_IDLE;
               end
               bsu_pkg::MODE_FORCE: begin
                  idx_in   = 2'd0;
                  state_in = bsu_pkg::ST_FMUL1;
               end
               bsu_pkg::MODE_FINAL: begin
                  state_in = bsu_pkg::ST_OUT;
               end
               default: begin
                  state_in = bsu_pkg::ST_IDLE;
               end
            endcase
         end

         bsu_pkg::ST_FMUL1: begin
            state_in = bsu_pkg::ST_FSUB;
         end

         bsu_pkg::ST_FSUB: begin
            fneg_in  = f_val[33];
            fmag_in  = f_val[33] ? 32'(-f_val) : f_val[31:0];
            state_in = bsu_pkg::ST_FMUL2;
         end

         bsu_pkg::ST_FMUL2: begin
            state_in = bsu_pkg::ST_FACC;
         end

         bsu_pkg::ST_FACC: begin
            acc_in[idx_ff] = acc_ff[idx_ff] + f_add;
            if (idx_ff == 2'd2) begin
               idx_in = 2'd0;
               if (frc_ff == bsu_pkg::FRC_ALIGN) begin
                  state_in = bsu_pkg::ST_VMUL_HI;
               end else begin
                  frc_in   = bsu_pkg::force_type'(frc_ff + 3'd1);
                  state_in = bsu_pkg::ST_DIR;
               end
            end else begin
               idx_in   = idx_ff + 2'd1;
               state_in = bsu_pkg::ST_FMUL1;
            end
         end

         bsu_pkg::ST_VMUL_HI: begin
            state_in = bsu_pkg::ST_VMUL_LO;
         end

         bsu_pkg::ST_VMUL_LO: begin
            tmp_in   = prod_ff[bsu_pkg::TMP_W-1:0];
            state_in = bsu_pkg::ST_VADD;
         end

         bsu_pkg::ST_VADD: begin
            vec_in[idx_ff] = VEC_W'(vel_ff[idx_ff]) + v_delta;
            if (idx_ff == 2'd2) begin
               mode_in  = bsu_pkg::MODE_FINAL;
               state_in = bsu_pkg::ST_NABS;
            end else begin
               idx_in   = idx_ff + 2'd1;
               state_in = bsu_pkg::ST_VMUL_HI;
            end
         end

         bsu_pkg::ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in       = 1'b1;
               rsp_data_in.dest_x = dest[0];
               rsp_data_in.dest_y = dest[1];
               rsp_data_in.dest_z = dest[2];
               for (int i = 0; i < 3; i++) begin
                  psum_in[i] = '0;
                  vsum_in[i] = '0;
               end
               ncnt_in  = '0;
               found_in = 1'b0;
               state_in = bsu_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = bsu_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bsu_pkg::ST_IDLE;
         mode_ff      <= bsu_pkg::MODE_FORCE;
         frc_ff       <= bsu_pkg::FRC_TARGET;
         idx_ff       <= '0;
         cnt_ff       <= '0;
         lsh_ff       <= '0;
         rsh_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         w_target_ff  <= 16'd256;
         w_avoid_ff   <= 16'd256;
         w_separ_ff   <= 16'd256;
         w_cohes_ff   <= 16'd256;
         w_align_ff   <= 16'd256;
         min_speed_ff <= 31'd0;
         max_speed_ff <= 31'd4096000;
         dt_ff        <= 16'd1092;
         ncnt_ff      <= '0;
         tvalid_ff    <= 1'b0;
         found_ff     <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            pos_ff[i]   <= '0;
            vel_ff[i]   <= '0;
            head_ff[i]  <= '0;
            tgt_ff[i]   <= '0;
            psum_ff[i]  <= '0;
            vsum_ff[i]  <= '0;
            avoid_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         frc_ff       <= frc_in;
         idx_ff       <= idx_in;
         cnt_ff       <= cnt_in;
         lsh_ff       <= lsh_in;
         rsh_ff       <= rsh_in;
         rsp_valid_ff <= rsp_valid_in;
         w_target_ff  <= w_target_in;
         w_avoid_ff   <= w_avoid_in;
         w_separ_ff   <= w_separ_in;
         w_cohes_ff   <= w_cohes_in;
         w_align_ff   <= w_align_in;
         min_speed_ff <= min_speed_in;
         max_speed_ff <= max_speed_in;
         dt_ff        <= dt_in;
         ncnt_ff      <= ncnt_in;
         tvalid_ff    <= tvalid_in;
         found_ff     <= found_in;
         for (int i = 0; i < 3; i++) begin
            pos_ff[i]   <= pos_in[i];
            vel_ff[i]   <= vel_in[i];
            head_ff[i]  <= head_in[i];
            tgt_ff[i]   <= tgt_in[i];
            psum_ff[i]  <= psum_in[i];
            vsum_ff[i]  <= vsum_in[i];
            avoid_ff[i] <= avoid_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      sq_ff       <= sq_in;
      root_ff     <= root_in;
      rem_ff      <= rem_in;
      dnum_ff     <= dnum_in;
      speed_ff    <= speed_in;
      prod_ff     <= prod_in;
      tmp_ff      <= tmp_in;
      fmag_ff     <= fmag_in;
      fneg_ff     <= fneg_in;
      rsp_data_ff <= rsp_data_in;
      for (int i = 0; i < 3; i++) begin
         vec_ff[i] <= vec_in[i];
         m_ff[i]   <= m_in[i];
         neg_ff[i] <= neg_in[i];
         q_ff[i]   <= q_in[i];
         acc_ff[i] <= acc_in[i];
      end
   end

   a_ncnt_bound: assert property (@(posedge clock) disable iff (reset)
      ncnt_ff <= CNT_W'(MAX_NEIGHBORS))
      else $error("neighbor count above limit");

   a_round_clear: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> (ncnt_ff == '0) && !found_ff)
      else $error("round state not cleared with result");

   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bsu_pkg::ST_NDIV) |-> (rem_ff < mag))
      else $error("divider remainder not below divisor");

   a_norm_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bsu_pkg::ST_NSQ_MUL) |->
         (64'(mx) < bsu_pkg::NORM_HI) && (64'(mx) >= bsu_pkg::NORM_LO))
      else $error("scaled vector out of normalization range");

endmodule

[tb/sv/tb_boid_steering_update.sv]
// ============================================================================
// tb_boid_steering_update - self-checking bench for the boid steering block
// Drives owner, aim, neighbor, probe and finish transactions with random gaps,
// predicts each destination with a fixed point model kept in the bench and
// compares every returned destination field by field, in order.
// ============================================================================
`timescale 1ns / 1ps

module tb_boid_steering_update;

   typedef longint tri_type [3];
   typedef longint unsigned utri_type [3];

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   bsu_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   bsu_pkg::rsp_type rsp_data;
   logic             csr_write_en = 1'b0;
   logic [2:0]       csr_index = bsu_pkg::CSR_TARGET_WEIGHT;
   logic [30:0]      csr_wdata = '0;

   boid_steering_update dut (.*);

   always #5 clock = ~clock;

   // ---- steering predictor state ----
   longint unsigned w_target, w_avoid, w_separ, w_cohes, w_align, dt_q16;
   longint unsigned spd_min, spd_max;
   tri_type boid_pos, boid_vel, boid_head, aim_pos, avoid_dir, flock_pos_sum, flock_vel_sum;
   bit aim_on, avoid_on;
   int flock_count;

   bsu_pkg::rsp_type dest_q[$];
   int errors = 0;
   bit no_idle = 0;
   int stall_left = 0;
   int quiet_cycles = 0;

   function automatic longint unsigned int_sqrt(input longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint mul_shift(input longint x, input longint unsigned k, input int sh);
      longint unsigned m, p;
      m = (x < 0) ? longint'(-x) : longint'(x);
      p = (m * k) >> sh;
      return (x < 0) ? -longint'(p) : longint'(p);
   endfunction

   function automatic void scale_vec(input tri_type v, output utri_type m, output bit neg[3],
                                     output longint unsigned mag, output int lsh, output int rsh);
      longint unsigned mx, sq;
      mx = 0;
      sq = 0;
      lsh = 0;
      rsh = 0;
      mag = 0;
      for (int i = 0; i < 3; i++) begin
         neg[i] = v[i] < 0;
         m[i] = neg[i] ? longint'(-v[i]) : longint'(v[i]);
         if (m[i] > mx) mx = m[i];
      end
      if (mx == 0) return;
      while (mx >= (64'd1 << 30)) begin
         for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
         mx = mx >> 1;
         rsh++;
      end
      while (mx < (64'd1 << 29)) begin
         for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
         mx = mx << 1;
         lsh++;
      end
      for (int i = 0; i < 3; i++) sq += m[i] * m[i];
      mag = int_sqrt(sq);
   endfunction

   function automatic void unit_dir(input tri_type v, output tri_type u);
      utri_type m;
      bit neg[3];
      longint unsigned mag, q;
      int lsh, rsh;
      scale_vec(v, m, neg, mag, lsh, rsh);
      for (int i = 0; i < 3; i++) begin
         q = (mag != 0) ? (m[i] * 4096) / mag : 0;
         u[i] = neg[i] ? -longint'(q) : longint'(q);
      end
   endfunction

   function automatic void add_steer(input tri_type dir, input longint unsigned w,
                                     inout tri_type acc);
      tri_type u;
      longint f;
      unit_dir(dir, u);
      for (int i = 0; i < 3; i++) begin
         f = mul_shift(u[i], spd_max, 12) - boid_vel[i];
         acc[i] += mul_shift(f, w, 8);
      end
   endfunction

   function automatic void reset_model();
      w_target = 256; w_avoid = 256; w_separ = 256; w_cohes = 256; w_align = 256;
      spd_min = 0; spd_max = 4096000; dt_q16 = 1092;
      for (int i = 0; i < 3; i++) begin
         boid_pos[i] = 0; boid_vel[i] = 0; boid_head[i] = 0; aim_pos[i] = 0;
         avoid_dir[i] = 0; flock_pos_sum[i] = 0; flock_vel_sum[i] = 0;
      end
      aim_on = 0; avoid_on = 0; flock_count = 0;
   endfunction

   function automatic void steer_step(input bsu_pkg::req_type t);
      tri_type a, b, d, acc, nv;
      utri_type m;
      bit neg[3];
      longint unsigned mag, speed, q;
      int lsh, rsh;
      longint r;
      bsu_pkg::rsp_type res;
      a[0] = t.vec_a_x; a[1] = t.vec_a_y; a[2] = t.vec_a_z;
      b[0] = t.vec_b_x; b[1] = t.vec_b_y; b[2] = t.vec_b_z;
      case (t.op)
         bsu_pkg::OP_OWN: for (int i = 0; i < 3; i++) begin
            boid_pos[i] = a[i];
            boid_vel[i] = b[i];
         end
         bsu_pkg::OP_AIM: begin
            for (int i = 0; i < 3; i++) begin
               boid_head[i] = a[i];
               aim_pos[i] = b[i];
            end
            aim_on = t.flag;
         end
         bsu_pkg::OP_NEIGHBOR: if (flock_count < 256) begin
            for (int i = 0; i < 3; i++) begin
               flock_pos_sum[i] += a[i];
               flock_vel_sum[i] += b[i];
            end
            flock_count++;
         end
         bsu_pkg::OP_PROBE: if (t.flag && !avoid_on) begin
            for (int i = 0; i < 3; i++) d[i] = a[i] - boid_pos[i];
            unit_dir(d, avoid_dir);
            avoid_on = 1;
         end
         bsu_pkg::OP_FINISH: begin
            for (int i = 0; i < 3; i++) begin
               acc[i] = 0;
               d[i] = aim_on ? aim_pos[i] - boid_pos[i] : 0;
            end
            add_steer(d, w_target, acc);
            add_steer(avoid_on ? avoid_dir : boid_head, w_avoid, acc);
            for (int i = 0; i < 3; i++) d[i] = boid_pos[i] * flock_count - flock_pos_sum[i];
            add_steer(d, w_separ, acc);
            for (int i = 0; i < 3; i++) d[i] = -d[i];
            add_steer(d, w_cohes, acc);
            add_steer(flock_vel_sum, w_align, acc);
            for (int i = 0; i < 3; i++) nv[i] = boid_vel[i] + mul_shift(acc[i], dt_q16, 16);
            scale_vec(nv, m, neg, mag, lsh, rsh);
            speed = 0;
            if (mag != 0) begin
               speed = (rsh != 0) ? (mag << rsh) : (mag >> lsh);
               if (speed < spd_min) speed = spd_min;
               else if (!(speed < spd_max)) speed = spd_max;
            end
            for (int i = 0; i < 3; i++) begin
               q = (mag != 0) ? (m[i] * speed) / mag : 0;
               r = boid_pos[i] + (neg[i] ? -longint'(q) : longint'(q));
               if (r > 64'sd2147483647) r = 64'sd2147483647;
               if (r < -64'sd2147483648) r = -64'sd2147483648;
               if (i == 0) res.dest_x = r[31:0];
               else if (i == 1) res.dest_y = r[31:0];
               else res.dest_z = r[31:0];
            end
            dest_q.push_back(res);
            for (int i = 0; i < 3; i++) begin
               flock_pos_sum[i] = 0;
               flock_vel_sum[i] = 0;
            end
            flock_count = 0;
            avoid_on = 0;
         end
         default: ;
      endcase
   endfunction

   // ---- stimulus helpers ----
   function automatic int gap_len();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [31:0] rand_coord();
      int r;
      r = $urandom_range(0, 99);
      if (r < 30) return $urandom;
      if (r < 80) return 32'($signed($urandom_range(0, 2000000)) - 1000000);
      if (r < 85) return 32'h7FFF_FFFF;
      if (r < 90) return 32'h8000_0000;
      if (r < 95) return 32'($signed($urandom_range(0, 200)) - 100);
      return 32'd0;
   endfunction

   function automatic bsu_pkg::req_type make_item(input logic [2:0] op, input logic flag);
      bsu_pkg::req_type t;
      t.op = op; t.flag = flag;
      t.vec_a_x = rand_coord(); t.vec_a_y = rand_coord(); t.vec_a_z = rand_coord();
      t.vec_b_x = rand_coord(); t.vec_b_y = rand_coord(); t.vec_b_z = rand_coord();
      return t;
   endfunction

   task automatic send_item(input bsu_pkg::req_type t);
      int g;
      g = gap_len();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= t;
      do @(posedge clock); while (req_stall);
      steer_step(t);
   endtask

   // drops valid right after the last accepted transaction so nothing repeats
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (dest_q.size() != 0);
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [30:0] val);
      wait_drained();
      repeat (400) @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         bsu_pkg::CSR_TARGET_WEIGHT:     w_target = val[15:0];
         bsu_pkg::CSR_AVOID_WEIGHT:      w_avoid = val[15:0];
         bsu_pkg::CSR_SEPARATION_WEIGHT: w_separ = val[15:0];
         bsu_pkg::CSR_COHESION_WEIGHT:   w_cohes = val[15:0];
         bsu_pkg::CSR_ALIGNMENT_WEIGHT:  w_align = val[15:0];
         bsu_pkg::CSR_MIN_SPEED:         spd_min = val;
         bsu_pkg::CSR_MAX_SPEED:         spd_max = val;
         bsu_pkg::CSR_DELTA_TIME:        dt_q16 = val[15:0];
         default: ;
      endcase
   endtask

   task automatic set_all(input logic [15:0] w, input logic [30:0] lo, input logic [30:0] hi,
                          input logic [15:0] dt);
      csr_write(bsu_pkg::CSR_TARGET_WEIGHT, 31'(w));
      csr_write(bsu_pkg::CSR_AVOID_WEIGHT, 31'(w));
      csr_write(bsu_pkg::CSR_SEPARATION_WEIGHT, 31'(w));
      csr_write(bsu_pkg::CSR_COHESION_WEIGHT, 31'(w));
      csr_write(bsu_pkg::CSR_ALIGNMENT_WEIGHT, 31'(w));
      csr_write(bsu_pkg::CSR_MIN_SPEED, lo);
      csr_write(bsu_pkg::CSR_MAX_SPEED, hi);
      csr_write(bsu_pkg::CSR_DELTA_TIME, 31'(dt));
   endtask

   // one well formed round: owner, aim, neighbors, probes, finish
   task automatic send_round(input int max_nb);
      int nb, np;
      send_item(make_item(bsu_pkg::OP_OWN, 1'($urandom_range(0, 1))));
      send_item(make_item(bsu_pkg::OP_AIM, 1'($urandom_range(0, 1))));
      nb = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, max_nb);
      repeat (nb) send_item(make_item(bsu_pkg::OP_NEIGHBOR, 1'($urandom_range(0, 1))));
      np = $urandom_range(0, 3);
      repeat (np) send_item(make_item(bsu_pkg::OP_PROBE, 1'($urandom_range(0, 1))));
      send_item(make_item(bsu_pkg::OP_FINISH, 1'($urandom_range(0, 1))));
   endtask

   // ---- tests ----
   task automatic test_directed();
      bsu_pkg::req_type t;
      send_item(make_item(bsu_pkg::OP_FINISH, 1'b0));
      t = '0;
      t.op = bsu_pkg::OP_OWN;
      t.vec_a_x = 32'h7FFF_F000; t.vec_a_y = 32'h8000_0000; t.vec_a_z = 32'd0;
      t.vec_b_x = 32'h7FFF_FFFF; t.vec_b_y = 32'h8000_0000; t.vec_b_z = 32'h0000_1000;
      send_item(t);
      t = '0;
      t.op = bsu_pkg::OP_AIM; t.flag = 1'b0;
      send_item(t);
      send_item(make_item(bsu_pkg::OP_FINISH, 1'b0));
      t.op = bsu_pkg::OP_AIM; t.flag = 1'b1;
      t.vec_a_x = 32'h0000_1000; t.vec_b_x = 32'h8000_0000; t.vec_b_y = 32'h7FFF_FFFF;
      send_item(t);
      t = '0;
      t.op = bsu_pkg::OP_NEIGHBOR;
      t.vec_a_x = 32'h7FFF_FFFF; t.vec_b_z = 32'h8000_0000;
      send_item(t);
      t.vec_a_x = 32'h8000_0000; t.vec_a_y = 32'hFFFF_FFFF; t.vec_b_z = 32'h7FFF_FFFF;
      send_item(t);
      t = '0;
      t.op = bsu_pkg::OP_PROBE; t.flag = 1'b0; t.vec_a_y = 32'h0010_0000;
      send_item(t);
      t.flag = 1'b1;
      send_item(t);
      t.vec_a_z = 32'h8000_0000;
      send_item(t);
      for (int op = 5; op < 8; op++) send_item(make_item(3'(op), 1'b1));
      send_item(make_item(bsu_pkg::OP_FINISH, 1'b1));
      t = '0;
      t.op = bsu_pkg::OP_OWN; t.vec_a_x = 32'h7FFF_FFFF; t.vec_a_y = 32'h8000_0000;
      t.vec_b_x = 32'h0100_0000; t.vec_b_y = 32'hFF00_0000;
      send_item(t);
      t = '0;
      t.op = bsu_pkg::OP_AIM; t.vec_a_x = 32'h0000_1000;
      send_item(t);
      send_item(make_item(bsu_pkg::OP_PROBE, 1'b1));
      send_item(make_item(bsu_pkg::OP_FINISH, 1'b0));
   endtask

   task automatic test_neighbor_overflow();
      send_item(make_item(bsu_pkg::OP_OWN, 1'b0));
      send_item(make_item(bsu_pkg::OP_AIM, 1'b1));
      repeat (300) send_item(make_item(bsu_pkg::OP_NEIGHBOR, 1'b0));
      send_item(make_item(bsu_pkg::OP_FINISH, 1'b0));
   endtask

   task automatic test_config_extremes();
      set_all(16'hFFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 16'hFFFF);
      repeat (4) send_round(6);
      set_all(16'h0000, 31'd0, 31'd0, 16'h0000);
      repeat (4) send_round(6);
      set_all(16'h0100, 31'd8000000, 31'd4096, 16'h8000);
      repeat (4) send_round(6);
      set_all(16'h0080, 31'd4096, 31'd40960000, 16'd1092);
      repeat (4) send_round(6);
   endtask

   task automatic test_random_flock();
      int sent_rounds;
      sent_rounds = 0;
      repeat (210) begin
         if (sent_rounds % 60 == 59) begin
            csr_write(3'($urandom_range(0, 7)), 31'($urandom));
            csr_write(bsu_pkg::CSR_MAX_SPEED, 31'($urandom_range(0, 80000000)));
            csr_write(bsu_pkg::CSR_MIN_SPEED, 31'($urandom_range(0, 4000000)));
         end
         if (sent_rounds % 40 == 20) no_idle = ~no_idle;
         if (sent_rounds == 150) wait_drained();
         if ($urandom_range(0, 9) == 0)
            send_item(make_item(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1))));
         else
            send_round(($urandom_range(0, 9) == 0) ? 12 : 4);
         sent_rounds++;
      end
      no_idle = 0;
   endtask

   // ---- result side ----
   always @(posedge clock) begin
      if (no_idle) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
         stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                 : $urandom_range(0, 3);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      bsu_pkg::rsp_type exp_dest;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (dest_q.size() == 0) begin
            $display("%0t: unexpected transaction, expected none, actual %h", $time,
                     rsp_data);
            errors++;
         end else begin
            exp_dest = dest_q.pop_front();
            if (rsp_data.dest_x !== exp_dest.dest_x) begin
               $display("%0t: dest_x expected %0d actual %0d", $time, exp_dest.dest_x,
                        rsp_data.dest_x);
               errors++;
            end
            if (rsp_data.dest_y !== exp_dest.dest_y) begin
               $display("%0t: dest_y expected %0d actual %0d", $time, exp_dest.dest_y,
                        rsp_data.dest_y);
               errors++;
            end
            if (rsp_data.dest_z !== exp_dest.dest_z) begin
               $display("%0t: dest_z expected %0d actual %0d", $time, exp_dest.dest_z,
                        rsp_data.dest_z);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 30000) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      reset_model();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_neighbor_overflow();
      test_config_extremes();
      test_random_flock();
      wait_drained();
      repeat (400) @(posedge clock);
      if (errors == 0 && dest_q.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
